[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks at posedge clk; JSS_ASSERT is disabled while rst_n is low, JSS_ASSERT_ALWAYS is not
`ifndef SYNTHESIS
`define JSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSS_ASSERT(lbl, prop, msg)
`define JSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/jss_pkg.sv]
package jss_pkg;

  localparam logic [1:0] FUNC_INSTR = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_RESET = 2'd3;

  localparam int WORD_BITS = 32;
  localparam logic [2:0] RESET_HIGH_CYCLES = 3'd5;
  localparam int DEBUG_BIT = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  bit_count;
    logic [31:0] shift_in;
    logic        tdo;
  } in_item_t;

  typedef struct packed {
    logic        drive;
    logic        tms;
    logic        tdi;
    logic        done_res;
    logic [31:0] captured;
    logic        debug_mode;
    logic        rejected;
  } out_item_t;

endpackage

[sv/jss_core.sv]
`include "assert_macros.svh"

module jss_core #(
  parameter int SCAN_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  jss_pkg::in_item_t item,
  output jss_pkg::out_item_t result
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PRE   = 3'd1;
  localparam logic [2:0] PH_SHIFT = 3'd2;
  localparam logic [2:0] PH_POST  = 3'd3;
  localparam logic [2:0] PH_RESET = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  step_count_r, step_count_nxt;
  logic        kind_data_r, kind_data_nxt;
  logic [31:0] send_bits_r, send_bits_nxt;
  logic [31:0] read_bits_r, read_bits_nxt;
  logic [5:0]  bits_left_r, bits_left_nxt;
  logic [5:0]  shift_idx_r, shift_idx_nxt;
  logic [6:0]  count_ext;
  logic [2:0]  step_inc;
  logic [2:0]  prefix_len;

  assign count_ext  = {1'b0, item.bit_count};
  assign step_inc   = step_count_r + 3'd1;
  assign prefix_len = kind_data_r ? 3'd3 : 3'd4;

  always_comb begin
    result         = '0;
    phase_nxt      = phase_r;
    step_count_nxt = step_count_r;
    kind_data_nxt  = kind_data_r;
    send_bits_nxt  = send_bits_r;
    read_bits_nxt  = read_bits_r;
    bits_left_nxt  = bits_left_r;
    shift_idx_nxt  = shift_idx_r;

    if (item.func != jss_pkg::FUNC_TICK) begin
      if (phase_r != PH_IDLE) begin
        result.rejected = 1'b1;
      end else begin
        step_count_nxt = '0;
        read_bits_nxt  = '0;
        shift_idx_nxt  = '0;
        if (item.func == jss_pkg::FUNC_RESET) begin
          phase_nxt = PH_RESET;
        end else begin
          kind_data_nxt = (item.func == jss_pkg::FUNC_DATA);
          send_bits_nxt = item.shift_in;
          if (count_ext > 7'(SCAN_BITS)) begin
            bits_left_nxt = 6'(SCAN_BITS);
          end else begin
            bits_left_nxt = item.bit_count;
          end
          phase_nxt = PH_PRE;
        end
      end
    end else begin
      case (phase_r)
        PH_PRE: begin
          result.drive = 1'b1;
          result.tdi   = 1'b1;
          // instruction walk 1,1,0,0; data walk 1,0,0
          if (kind_data_r) begin
            result.tms = (step_count_r == 3'd0) || (step_count_r >= 3'd3);
          end else begin
            result.tms = ~step_count_r[1];
          end
          step_count_nxt = step_inc;
          if (step_inc >= prefix_len) begin
            step_count_nxt = '0;
            phase_nxt = (bits_left_r != 6'd0) ? PH_SHIFT : PH_POST;
          end
        end
        PH_SHIFT: begin
          result.drive = 1'b1;
          result.tms   = (bits_left_r == 6'd1);
          // bits past the word send 0 and drop tdo
          if (shift_idx_r < 6'(jss_pkg::WORD_BITS)) begin
            result.tdi = send_bits_r[shift_idx_r[4:0]];
            read_bits_nxt[shift_idx_r[4:0]] = item.tdo;
          end
          shift_idx_nxt = shift_idx_r + 6'd1;
          bits_left_nxt = bits_left_r - 6'd1;
          if (bits_left_r == 6'd1) begin
            phase_nxt = PH_POST;
          end
        end
        PH_POST: begin
          result.drive    = 1'b1;
          result.tms      = 1'b1;
          result.tdi      = 1'b1;
          result.done_res = 1'b1;
          result.captured = read_bits_r;
          result.debug_mode = ~kind_data_r & read_bits_r[jss_pkg::DEBUG_BIT];
          phase_nxt = PH_IDLE;
        end
        PH_RESET: begin
          result.drive = 1'b1;
          result.tdi   = 1'b1;
          if (step_count_r < jss_pkg::RESET_HIGH_CYCLES) begin
            result.tms     = 1'b1;
            step_count_nxt = step_inc;
          end else begin
            result.done_res = 1'b1;
            step_count_nxt  = '0;
            phase_nxt       = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      step_count_r <= '0;
      kind_data_r  <= 1'b0;
      send_bits_r  <= '0;
      read_bits_r  <= '0;
      bits_left_r  <= '0;
      shift_idx_r  <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      step_count_r <= step_count_nxt;
      kind_data_r  <= kind_data_nxt;
      send_bits_r  <= send_bits_nxt;
      read_bits_r  <= read_bits_nxt;
      bits_left_r  <= bits_left_nxt;
      shift_idx_r  <= shift_idx_nxt;
    end
  end

  `JSS_ASSERT(a_reject_keeps_phase, (step_en && result.rejected) |=> $stable(phase_r), "rejected command changed the phase")
  `JSS_ASSERT(a_shift_has_bits, (phase_r == PH_SHIFT) |-> (bits_left_r != 6'd0), "shift phase with no bits left")
  `JSS_ASSERT(a_done_to_idle, (step_en && result.done_res) |=> (phase_r == PH_IDLE), "sequence end did not return to idle")
  `JSS_ASSERT(a_idle_step_clear, (phase_r == PH_IDLE) |-> (step_count_r == 3'd0), "step count left over in idle")

endmodule

[sv/jss_out_reg.sv]
module jss_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_req,
  input  jss_pkg::out_item_t load_data,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output jss_pkg::out_item_t out_data
);

  logic               valid_r;
  jss_pkg::out_item_t data_r;

  // free when empty or when the held transaction leaves this cycle
  assign advance   = ~valid_r | ~out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load_req;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_req) begin
      data_r <= load_data;
    end
  end

endmodule

[sv/jtag_scan_sequencer.sv]
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------
// input    | in_valid / in_stall  | in_data  (func, bit_count, shift_in, tdo)
// result   | out_valid / out_stall| out_data (drive, tms, tdi, done_res, ...)
//
// one transaction per clock sustained while in_stall is low; each result is carried
// from its input through the input register and then the result register.
// the sequencer state advances in the single step between those registers.
// reset (rst_n low, synchronous) empties both registers and returns the TAP
// walker to idle. out_stall holds the result; in_stall rises only while both
// registers are full and the result is stalled.
module jtag_scan_sequencer #(
  parameter int SCAN_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jss_pkg::out_item_t out_data
);

  logic               in_valid_r;
  jss_pkg::in_item_t  in_data_r;
  logic               out_advance;
  logic               step_en;
  jss_pkg::out_item_t step_result;

  assign step_en  = in_valid_r & out_advance;
  assign in_stall = in_valid_r & ~out_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  jss_core #(
    .SCAN_BITS (SCAN_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data_r),
    .result  (step_result)
  );

  jss_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_req  (step_en),
    .load_data (step_result),
    .advance   (out_advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[verif/tap_result_checker.sv]
// watches both channels of the scan sequencer, predicts every result
// from the accepted input transactions and compares them in order
module tap_result_checker #(
  parameter int SCAN_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  jss_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  jss_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending,
  output int                 results_seen,
  output int                 walks_done,
  output int                 refusals
);

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_PREFIX,
    WALK_SHIFT,
    WALK_UPDATE,
    WALK_TAPRST
  } walk_phase_t;

  localparam int INSTR_PREFIX_LEN = 4;
  localparam int DATA_PREFIX_LEN  = 3;
  // tms per prefix step, step 0 in bit 0
  localparam logic [3:0] INSTR_TMS = 4'b0011;
  localparam logic [2:0] DATA_TMS  = 3'b001;

  walk_phase_t phase_q;
  logic [5:0]  step_q;
  logic        instr_q;
  logic [31:0] tx_bits;
  logic [31:0] rx_bits;
  logic [6:0]  remaining;
  logic [6:0]  bit_pos;

  jss_pkg::out_item_t expected_pins[$];

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
    walks_done   = 0;
    refusals     = 0;
  end

  task automatic clear_walker();
    phase_q   = WALK_IDLE;
    step_q    = '0;
    instr_q   = 1'b0;
    tx_bits   = '0;
    rx_bits   = '0;
    remaining = '0;
    bit_pos   = '0;
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] result %0d: %s", $realtime, results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
  endtask

  task automatic step_tap_walker(input jss_pkg::in_item_t it,
                                 output jss_pkg::out_item_t res);
    int nbits;
    res = '0;
    if (it.func != jss_pkg::FUNC_TICK) begin
      if (phase_q != WALK_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        step_q  = '0;
        rx_bits = '0;
        bit_pos = '0;
        if (it.func == jss_pkg::FUNC_RESET) begin
          phase_q = WALK_TAPRST;
        end else begin
          nbits     = (it.bit_count > SCAN_BITS) ? SCAN_BITS : it.bit_count;
          instr_q   = (it.func == jss_pkg::FUNC_INSTR);
          tx_bits   = it.shift_in;
          remaining = 7'(nbits);
          phase_q   = WALK_PREFIX;
        end
      end
      return;
    end
    case (phase_q)
      WALK_PREFIX: begin
        res.drive = 1'b1;
        res.tdi   = 1'b1;
        res.tms   = instr_q ? INSTR_TMS[step_q[1:0]] : DATA_TMS[step_q[1:0]];
        step_q++;
        if (step_q >= (instr_q ? INSTR_PREFIX_LEN : DATA_PREFIX_LEN)) begin
          step_q  = '0;
          phase_q = (remaining != 0) ? WALK_SHIFT : WALK_UPDATE;
        end
      end
      WALK_SHIFT: begin
        res.drive = 1'b1;
        res.tms   = (remaining == 1);
        if (bit_pos < jss_pkg::WORD_BITS) begin
          res.tdi          = tx_bits[bit_pos];
          rx_bits[bit_pos] = it.tdo;
        end
        bit_pos++;
        remaining--;
        if (remaining == 0) phase_q = WALK_UPDATE;
      end
      WALK_UPDATE: begin
        res.drive      = 1'b1;
        res.tms        = 1'b1;
        res.tdi        = 1'b1;
        res.done_res   = 1'b1;
        res.captured   = rx_bits;
        res.debug_mode = instr_q ? rx_bits[jss_pkg::DEBUG_BIT] : 1'b0;
        phase_q        = WALK_IDLE;
      end
      WALK_TAPRST: begin
        res.drive = 1'b1;
        res.tdi   = 1'b1;
        if (step_q < jss_pkg::RESET_HIGH_CYCLES) begin
          res.tms = 1'b1;
          step_q++;
        end else begin
          res.done_res = 1'b1;
          step_q       = '0;
          phase_q      = WALK_IDLE;
        end
      end
      default: phase_q = WALK_IDLE;
    endcase
  endtask

  always @(posedge clk) begin : watch
    jss_pkg::out_item_t predicted;
    jss_pkg::out_item_t want;
    if (!rst_n) begin
      clear_walker();
      expected_pins.delete();
    end else begin
      if (in_valid && !in_stall) begin
        step_tap_walker(in_data, predicted);
        expected_pins.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_pins.size() == 0) begin
          report_mismatch("result transaction with nothing predicted");
        end else begin
          want = expected_pins.pop_front();
          if (want.done_res) walks_done++;
          if (want.rejected) refusals++;
          check_field("drive", out_data.drive, want.drive);
          check_field("tms", out_data.tms, want.tms);
          check_field("tdi", out_data.tdi, want.tdi);
          check_field("done_res", out_data.done_res, want.done_res);
          check_field("captured", out_data.captured, want.captured);
          check_field("debug_mode", out_data.debug_mode, want.debug_mode);
          check_field("rejected", out_data.rejected, want.rejected);
        end
      end
    end
    pending = expected_pins.size();
  end

endmodule

[verif/tb_jtag_scan_sequencer.sv]
module tb_jtag_scan_sequencer;

  localparam int SCAN_BITS   = 32;
  localparam int ITEMS       = 1550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_START  = 1500;
  localparam int HOLD_LEN    = 90;
  localparam int DRAIN_LEN   = 8;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  jss_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  jss_pkg::out_item_t out_data;

  int errors;
  int pending;
  int results_seen;
  int walks_done;
  int refusals;

  int items_sent;
  int burst_left;

  jtag_scan_sequencer #(.SCAN_BITS(SCAN_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tap_result_checker #(.SCAN_BITS(SCAN_BITS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .walks_done   (walks_done),
    .refusals     (refusals)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timed out with %0d results still outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: changing stall patterns plus one long hold-off to back the block up
  initial begin : receiver
    int rx_cyc;
    rx_cyc    = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN) begin
        out_stall = 1'b1;
      end else begin
        case ((rx_cyc / 150) % 4)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(99) < 25);
          2: out_stall = ($urandom_range(99) < 70);
          default: out_stall = ((rx_cyc % 7) < 3);
        endcase
      end
    end
  end

  function automatic jss_pkg::in_item_t mk_item(logic [1:0] f, logic [5:0] n,
                                                logic [31:0] d, logic t);
    jss_pkg::in_item_t it;
    it.func      = f;
    it.bit_count = n;
    it.shift_in  = d;
    it.tdo       = t;
    return it;
  endfunction

  function automatic int walk_cycles(logic [1:0] f, logic [5:0] n);
    if (f == jss_pkg::FUNC_RESET) return jss_pkg::RESET_HIGH_CYCLES + 1;
    return ((f == jss_pkg::FUNC_INSTR) ? 4 : 3) + ((n > SCAN_BITS) ? SCAN_BITS : n) + 1;
  endfunction

  // sender works in bursts; called and returns at a falling edge
  task automatic offer(input jss_pkg::in_item_t it);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(120, 40)
                                            : $urandom_range(12, 1);
    end
    in_valid = 1'b1;
    in_data  = it;
    burst_left--;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic jss_pkg::in_item_t rand_tick();
    return mk_item(jss_pkg::FUNC_TICK, 6'($urandom), $urandom, 1'($urandom));
  endfunction

  // ticks that carry a walk through; sometimes slip in a command that must be refused
  task automatic run_ticks(input int n, input int noise_pct);
    logic [1:0] f;
    repeat (n) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: f = jss_pkg::FUNC_INSTR;
          1: f = jss_pkg::FUNC_DATA;
          default: f = jss_pkg::FUNC_RESET;
        endcase
        offer(mk_item(f, 6'($urandom), $urandom, 1'($urandom)));
      end
      offer(rand_tick());
    end
  endtask

  initial begin : stimulus
    logic [1:0]  f;
    logic [5:0]  n;
    logic [31:0] d;
    int          r;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle tick, tap reset with a refused command inside it,
    // empty instruction scan, single-bit data scan
    offer(mk_item(jss_pkg::FUNC_TICK, '1, '1, 1'b1));
    offer(mk_item(jss_pkg::FUNC_RESET, '1, '1, 1'b0));
    run_ticks(2, 0);
    offer(mk_item(jss_pkg::FUNC_INSTR, 6'd8, 32'h5, 1'b1));
    run_ticks(4, 0);
    offer(mk_item(jss_pkg::FUNC_INSTR, '0, '0, 1'b0));
    run_ticks(walk_cycles(jss_pkg::FUNC_INSTR, '0), 0);
    offer(mk_item(jss_pkg::FUNC_DATA, 6'd1, '1, 1'b1));
    run_ticks(walk_cycles(jss_pkg::FUNC_DATA, 6'd1), 0);

    while (items_sent < ITEMS) begin
      r = $urandom_range(99);
      if (r < 15) f = jss_pkg::FUNC_RESET;
      else if (r < 57) f = jss_pkg::FUNC_INSTR;
      else f = jss_pkg::FUNC_DATA;
      r = $urandom_range(99);
      if (r < 10) n = '0;
      else if (r < 20) n = 6'(SCAN_BITS);
      else if (r < 30) n = 6'($urandom_range(63, SCAN_BITS + 1));
      else n = 6'($urandom_range(SCAN_BITS - 1, 1));
      r = $urandom_range(9);
      if (r == 0) d = '1;
      else if (r == 1) d = '0;
      else d = $urandom;
      offer(mk_item(f, n, d, 1'($urandom)));
      run_ticks(walk_cycles(f, n), 4);
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(3, 1)) offer(rand_tick());
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_LEN) @(negedge clk);

    $display("covered %0d input transactions and %0d results, long receiver hold-off included",
             items_sent, results_seen);
    $display("%0d scans or tap resets completed, %0d commands refused while busy",
             walks_done, refusals);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
